FILE: sv/sslf_pkg.sv
// shared constants, codes and types of the sub-pixel scaled line filter
package sslf_pkg;

   // storage sizes
   localparam int COEF_DEPTH = 512;
   localparam int LINE_DEPTH = 256;
   localparam int MAX_TAPS   = 8;

   localparam int COEF_AW = $clog2(COEF_DEPTH);
   localparam int LINE_AW = $clog2(LINE_DEPTH);
   localparam int TAP_W   = $clog2(MAX_TAPS + 1);
   localparam int K_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   // field and register widths
   localparam int CIDX_W = 9;
   localparam int COEF_W = 16;
   localparam int PIDX_W = 8;
   localparam int PIX_W  = 8;
   localparam int X_W    = 8;
   localparam int TCNT_W = 4;
   localparam int STEP_W = 10;
   localparam int FOFS_W = 9;
   localparam int SOFS_W = 9;

   // request word layout, lowest field first
   localparam int CIDX_LO  = 0;
   localparam int COEF_LO  = CIDX_LO + CIDX_W;
   localparam int PIDX_LO  = COEF_LO + COEF_W;
   localparam int PIXV_LO  = PIDX_LO + PIDX_W;
   localparam int X_LO     = PIXV_LO + PIX_W;
   localparam int REQ_DW   = ((X_LO + X_W + 7) / 8) * 8;
   localparam int REQ_UW   = 2;
   localparam int RSP_DW   = PIX_W;
   localparam int RSP_UW   = 1;

   // filter arithmetic
   localparam int BANK_SIZE   = 128;
   localparam int BANK_W      = $clog2(BANK_SIZE);
   localparam int PHASE_BITS  = 4;
   localparam int ROUND_ADD   = 64;
   localparam int ROUND_SHIFT = 7;
   localparam int PIX_MAX     = 255;
   localparam int PHASE_W     = X_W + STEP_W + 1;
   localparam int IDX_W       = PHASE_W - PHASE_BITS + 2;
   localparam int PROD_W      = PIX_W + 1 + COEF_W;
   localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS) + 1;

   // divider for the initial phase, two quotient bits a cycle
   localparam int DIV_CYC   = (BANK_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_CYC;
   localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

   // control register port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 10;

   typedef enum logic [CSR_AW-1:0] {
      CSR_TAP_COUNT     = 2'd0,
      CSR_PHASE_STEP    = 2'd1,
      CSR_FILTER_OFFSET = 2'd2,
      CSR_SOURCE_OFFSET = 2'd3
   } csr_type;

   typedef enum logic [REQ_UW-1:0] {
      ACT_LOAD_COEF  = 2'd0,
      ACT_LOAD_PIXEL = 2'd1,
      ACT_COMPUTE    = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_PHASE,
      S_ADDR,
      S_MAC,
      S_DRAIN,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic           load_coef;
      logic           load_pixel;
      logic           start;
      logic           phase;
      logic           addr;
      logic           issue;
      logic [K_W-1:0] k;
      logic           finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [TAP_W-1:0] taps;
      logic             div_last;
      logic             rsp_stall;
   } status_type;

endpackage

FILE: sv/subpel_scaled_line_filter_top.sv
// top level of the sub-pixel scaled line filter
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    tuser action, tdata load and compute fields
//   rsp_      out        rsp_tvalid/tready    tdata pixel_out, tuser out_of_range
//   csr_      in         csr_we               csr_addr register index, csr_wdata value
//
// load words are taken while idle; a compute word blocks further requests until it is done,
// taps being tap_count clamped to 1..8: the radix-4 divider steps, phase and address
// setup, the taps in turn on the shared mac, a drain and the hand-off
// the result register holds a finished word while the next request is taken, so a compute
// word only waits at its end while the previous result is still stalled
// reset is synchronous; the memories are not cleared and are undefined until loaded
module subpel_scaled_line_filter_top import sslf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // tdata: coef_index, coef_value, pixel_index, pixel_value, out_index, zero fill
   input  logic [REQ_DW-1:0] req_tdata,
   // tuser: action
   input  logic [REQ_UW-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata: pixel_out
   output logic [RSP_DW-1:0] rsp_tdata,
   // tuser: out_of_range
   output logic [RSP_UW-1:0] rsp_tuser,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type stat;

   // sequencer
   sslf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // filter datapath
   sslf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sv/sslf_div.sv
// radix-4 restoring divider for the filter start phase
module sslf_div import sslf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BANK_W-1:0] dividend,
   input  logic [TAP_W-1:0]  divisor,
   output logic              busy,
   output logic              last,
   output logic [BANK_W-1:0] quotient
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [TAP_W-1:0]     rem_ff, rem_in;
   logic [TAP_W-1:0]     div_ff;

   // two restoring steps per cycle
   always_comb begin
      logic [TAP_W:0]   r_v;
      logic [DIV_W-1:0] n_v;
      r_v = {1'b0, rem_ff};
      n_v = num_ff;
      for (int i = 0; i < 2; i++) begin
         r_v = {r_v[TAP_W-1:0], n_v[DIV_W-1]};
         n_v = {n_v[DIV_W-2:0], 1'b0};
         if (r_v >= {1'b0, div_ff}) begin
            r_v   = r_v - {1'b0, div_ff};
            n_v[0] = 1'b1;
         end
      end
      num_in = n_v;
      rem_in = r_v[TAP_W-1:0];
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_CYC);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // partial remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= DIV_W'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign last     = (cnt_ff == DIV_CNT_W'(1));
   assign quotient = num_ff[BANK_W-1:0];

endmodule

FILE: sv/sslf_dp.sv
// datapath: control registers, coefficient and line memories, shared mac, result register
module sslf_dp import sslf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [REQ_DW-1:0]  req_tdata,
   input  cmd_type            cmd,
   output status_type         stat,
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_addr,
   input  logic [CSR_DW-1:0]  csr_wdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_DW-1:0]  rsp_tdata,
   output logic [RSP_UW-1:0]  rsp_tuser
);

   localparam int BSUM_W = FOFS_W + 1;
   localparam logic signed [IDX_W-1:0] ONE_S = IDX_W'(1);

   // control registers
   logic [TCNT_W-1:0]        tap_count_ff;
   logic [STEP_W-1:0]        phase_step_ff;
   logic [FOFS_W-1:0]        filter_offset_ff;
   logic signed [SOFS_W-1:0] source_offset_ff;

   // memories
   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
   logic [PIX_W-1:0]         line_mem [LINE_DEPTH];

   // request fields
   logic [CIDX_W-1:0] coef_index;
   logic [COEF_W-1:0] coef_value;
   logic [PIDX_W-1:0] pixel_index;
   logic [PIX_W-1:0]  pixel_value;
   logic [X_W-1:0]    out_index;

   // compute pipeline
   logic [TAP_W-1:0]           taps;
   logic [X_W+STEP_W-1:0]      prod_ff;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [COEF_AW-1:0]         cbase_ff, cbase_in;
   logic signed [IDX_W-1:0]    idx_ff, idx_in;
   logic signed [IDX_W-1:0]    tap_s;
   logic                       tap_oob;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic [PIX_W-1:0]           pix_rd_ff;
   logic                       oob_rd_ff;
   logic                       rd_vld_ff;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       oor_acc_ff;
   logic signed [ACC_W:0]      rsum;
   logic signed [ACC_W:0]      rshift;
   logic [PIX_W-1:0]           pix_res;

   // divider hookup
   logic              div_busy;
   logic              div_last;
   logic [BANK_W-1:0] quot;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff;
   logic              rsp_oor_ff;

   assign coef_index  = req_tdata[COEF_LO-1:CIDX_LO];
   assign coef_value  = req_tdata[PIDX_LO-1:COEF_LO];
   assign pixel_index = req_tdata[PIXV_LO-1:PIDX_LO];
   assign pixel_value = req_tdata[X_LO-1:PIXV_LO];
   assign out_index   = req_tdata[X_LO+X_W-1:X_LO];

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= TCNT_W'(MAX_TAPS);
         phase_step_ff    <= STEP_W'(16);
         filter_offset_ff <= '0;
         source_offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_type'(csr_addr))
            CSR_TAP_COUNT:     tap_count_ff     <= csr_wdata[TCNT_W-1:0];
            CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_FILTER_OFFSET: filter_offset_ff <= csr_wdata[FOFS_W-1:0];
            CSR_SOURCE_OFFSET: source_offset_ff <= $signed(csr_wdata[SOFS_W-1:0]);
            default: ;
         endcase
      end
   end

   // effective tap count, clamped to 1..MAX_TAPS
   always_comb begin
      if (tap_count_ff == '0) begin
         taps = TAP_W'(1);
      end else if (TAP_W'(tap_count_ff) > TAP_W'(MAX_TAPS)) begin
         taps = TAP_W'(MAX_TAPS);
      end else begin
         taps = TAP_W'(tap_count_ff);
      end
   end

   // start = (offset within bank) / taps, doubled later
   sslf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (filter_offset_ff[BANK_W-1:0]),
      .divisor  (taps),
      .busy     (div_busy),
      .last     (div_last),
      .quotient (quot)
   );

   // phase, coefficient base and first tap index
   always_comb begin
      logic [PHASE_BITS+TAP_W-1:0] pt_v;
      logic [FOFS_W-1:0]           base_v;
      logic [BSUM_W-1:0]           bsum_v;
      logic signed [IDX_W-1:0]     src_v;
      logic signed [IDX_W-1:0]     half_v;
      logic signed [IDX_W-1:0]     sofs_v;
      phase_in = PHASE_W'(prod_ff) + PHASE_W'({quot, 1'b0});
      pt_v     = phase_ff[PHASE_BITS-1:0] * taps;
      base_v   = {filter_offset_ff[FOFS_W-1:BANK_W], {BANK_W{1'b0}}};
      bsum_v   = BSUM_W'(base_v) + BSUM_W'(pt_v >> 1);
      cbase_in = COEF_AW'(bsum_v);
      src_v    = $signed({2'b00, phase_ff[PHASE_W-1:PHASE_BITS]});
      half_v   = $signed({{(IDX_W-TAP_W+1){1'b0}}, taps[TAP_W-1:1]});
      sofs_v   = {{(IDX_W-SOFS_W){source_offset_ff[SOFS_W-1]}}, source_offset_ff};
      idx_in   = src_v - half_v + ONE_S + sofs_v;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         prod_ff <= out_index * phase_step_ff;
      end
      if (cmd.phase) begin
         phase_ff <= phase_in;
      end
      if (cmd.addr) begin
         cbase_ff <= cbase_in;
         idx_ff   <= idx_in;
      end
   end

   // tap k source index and range check
   assign tap_s   = idx_ff + $signed({{(IDX_W-K_W){1'b0}}, cmd.k});
   assign tap_oob = tap_s[IDX_W-1] || (tap_s[IDX_W-2:LINE_AW] != '0);

   // memory writes and tap reads
   always_ff @(posedge clock) begin
      if (cmd.load_coef) begin
         coef_mem[COEF_AW'(coef_index)] <= $signed(coef_value);
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[cbase_ff + COEF_AW'(cmd.k)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         line_mem[LINE_AW'(pixel_index)] <= pixel_value;
      end
      if (cmd.issue) begin
         pix_rd_ff <= line_mem[tap_s[LINE_AW-1:0]];
         oob_rd_ff <= tap_oob;
      end
   end

   // multiply-accumulate on the registered tap
   assign prod   = $signed({1'b0, pix_rd_ff}) * coef_rd_ff;
   assign acc_in = acc_ff + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         acc_ff     <= '0;
         oor_acc_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (!oob_rd_ff) begin
            acc_ff <= acc_in;
         end
         oor_acc_ff <= oor_acc_ff | oob_rd_ff;
      end
   end

   // round by 7 bits and clip to 0..255
   always_comb begin
      rsum   = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(ROUND_ADD);
      rshift = rsum >>> ROUND_SHIFT;
      if (oor_acc_ff || rsum[ACC_W]) begin
         pix_res = '0;
      end else if (rshift[ACC_W:PIX_W] != '0) begin
         pix_res = PIX_W'(PIX_MAX);
      end else begin
         pix_res = rshift[PIX_W-1:0];
      end
   end

   // result word register
   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_pix_ff <= pix_res;
         rsp_oor_ff <= oor_acc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_oor_ff;

   assign stat.taps      = taps;
   assign stat.div_last  = div_last & div_busy;
   assign stat.rsp_stall = rsp_valid_ff & ~rsp_tready;

`ifndef SYNTHESIS
   // an out-of-range result always carries a zero pixel
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_pix_ff == '0))
      else $error("out-of-range result with nonzero pixel");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten while stalled");
`endif

endmodule

FILE: sv/sslf_ctrl.sv
// controller: sequences loads, divide, address setup, tap loop and result hand-off
module sslf_ctrl import sslf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [REQ_UW-1:0] req_tuser,
   output logic              req_tready,
   input  status_type        stat,
   output cmd_type           cmd
);

   state_type      state_ff, state_in;
   logic [K_W-1:0] k_ff, k_in;

   // state and tap counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.k      = k_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (action_type'(req_tuser))
                  ACT_LOAD_COEF:  cmd.load_coef  = 1'b1;
                  ACT_LOAD_PIXEL: cmd.load_pixel = 1'b1;
                  ACT_COMPUTE: begin
                     cmd.start = 1'b1;
                     state_in  = S_DIV;
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (stat.div_last) begin
               state_in = S_PHASE;
            end
         end
         S_PHASE: begin
            cmd.phase = 1'b1;
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr = 1'b1;
            k_in     = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            cmd.issue = 1'b1;
            if (TAP_W'(k_ff) == stat.taps - TAP_W'(1)) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + K_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // tap counter stays inside the effective tap count
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (TAP_W'(k_ff) < stat.taps))
      else $error("tap counter past tap count");

   // an accepted compute word starts the divide
   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == ACT_COMPUTE)) |=> (state_ff == S_DIV))
      else $error("compute word did not start the divide");
`endif

endmodule

FILE: sim/subpel_scaled_line_filter_top_tb.sv
// self-checking testbench for the sub-pixel scaled line filter top level
module subpel_scaled_line_filter_top_tb;
   import sslf_pkg::*;

   localparam logic [REQ_UW-1:0] ACT_UNUSED = 2'd3;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_WORDS  = 90;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             off_line;
   } pixel_result_type;

   // filter predictor and queue of expected output pixels
   class pixel_scoreboard;
      int coef_mem [COEF_DEPTH];
      int line_mem [LINE_DEPTH];
      int tap_cnt = 8;
      int step    = 16;
      int fofs    = 0;
      int sofs    = 0;
      pixel_result_type expected_pixels [$];
      int errors = 0;

      function void write_reg(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
         case (addr)
            CSR_TAP_COUNT:     tap_cnt = int'(data[TCNT_W-1:0]);
            CSR_PHASE_STEP:    step    = int'(data[STEP_W-1:0]);
            CSR_FILTER_OFFSET: fofs    = int'(data[FOFS_W-1:0]);
            CSR_SOURCE_OFFSET: sofs    = int'($signed(data[SOFS_W-1:0]));
            default: ;
         endcase
      endfunction

      function pixel_result_type filter_pixel(int x);
         int taps, base, start, phase, src, centre, cbase, idx;
         longint acc;
         pixel_result_type r;
         // tap count saturates to 1..MAX_TAPS
         if (tap_cnt == 0) taps = 1;
         else if (tap_cnt > MAX_TAPS) taps = MAX_TAPS;
         else taps = tap_cnt;
         base   = (fofs / BANK_SIZE) * BANK_SIZE;
         start  = (fofs - base) / taps * 2;
         phase  = start + x * step;
         src    = phase >> PHASE_BITS;
         centre = taps / 2 - 1;
         cbase  = base + ((phase & 15) * taps) / 2;
         acc = 0;
         r.off_line = 1'b0;
         for (int k = 0; k < taps; k++) begin
            idx = src + k - centre + sofs;
            if (idx < 0 || idx >= LINE_DEPTH) begin
               r.off_line = 1'b1;
            end else begin
               acc += longint'(line_mem[idx]) * longint'(coef_mem[(cbase + k) % COEF_DEPTH]);
            end
         end
         // round by 7 bits, clip, force zero when a tap left the line
         acc += ROUND_ADD;
         if (r.off_line || acc < 0) r.pixel = '0;
         else if ((acc >>> ROUND_SHIFT) > PIX_MAX) r.pixel = PIX_W'(PIX_MAX);
         else r.pixel = PIX_W'(acc >>> ROUND_SHIFT);
         return r;
      endfunction

      function void note_word(logic [REQ_UW-1:0] act, logic [REQ_DW-1:0] data);
         case (act)
            ACT_LOAD_COEF:
               coef_mem[data[CIDX_LO +: CIDX_W]] = int'($signed(data[COEF_LO +: COEF_W]));
            ACT_LOAD_PIXEL:
               line_mem[data[PIDX_LO +: PIDX_W]] = int'(data[PIXV_LO +: PIX_W]);
            ACT_COMPUTE:
               expected_pixels.push_back(filter_pixel(int'(data[X_LO +: X_W])));
            default: ;
         endcase
      endfunction

      function void check_pixel(logic [RSP_DW-1:0] data, logic [RSP_UW-1:0] user);
         pixel_result_type e;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: expected nothing, actual %0d flag %0d",
                     $time, data, user);
            return;
         end
         e = expected_pixels.pop_front();
         if (data !== e.pixel) begin
            errors++;
            $display("%0t: pixel_out mismatch: expected %0d, actual %0d", $time, e.pixel, data);
         end
         if (user[0] !== e.off_line) begin
            errors++;
            $display("%0t: out_of_range mismatch: expected %0d, actual %0d",
                     $time, e.off_line, user[0]);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic [REQ_UW-1:0] req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [RSP_UW-1:0] rsp_tuser;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_DW-1:0] csr_wdata  = '0;

   pixel_scoreboard sb = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int quiet      = 0;

   subpel_scaled_line_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: every accepted word goes to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.note_word(req_tuser, req_tdata);
         if (csr_we) sb.write_reg(csr_addr, csr_wdata);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(input logic [REQ_UW-1:0] act, input int cidx, input int cval,
                            input int pidx, input int pval, input int x);
      logic [REQ_DW-1:0] data;
      data = '0;
      data[CIDX_LO +: CIDX_W] = CIDX_W'(cidx);
      data[COEF_LO +: COEF_W] = COEF_W'(cval);
      data[PIDX_LO +: PIDX_W] = PIDX_W'(pidx);
      data[PIXV_LO +: PIX_W]  = PIX_W'(pval);
      data[X_LO +: X_W]       = X_W'(x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_coef(input int idx, input int val);
      send_word(ACT_LOAD_COEF, idx, val, $urandom, $urandom, $urandom);
   endtask

   task automatic load_pixel(input int idx, input int val);
      send_word(ACT_LOAD_PIXEL, $urandom, $urandom, idx, val, $urandom);
   endtask

   task automatic compute(input int x);
      send_word(ACT_COMPUTE, $urandom, $urandom, $urandom, $urandom, x);
   endtask

   // wait until every expected pixel is back and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all four registers, unused upper bits random
   task automatic write_regs(input int taps, input int stp, input int fo, input int so);
      logic [CSR_DW-1:0] vals [4];
      vals[0] = {6'($urandom), 4'(taps)};
      vals[1] = 10'(stp);
      vals[2] = {1'($urandom), 9'(fo)};
      vals[3] = {1'($urandom), 9'(so)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= csr_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic pick_settings();
      int t, s, f, o;
      case ($urandom_range(9))
         0: t = 0;
         1: t = 15;
         2: t = 1;
         3: t = 8;
         default: t = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
         0: s = 0;
         1: s = 1023;
         2, 3: s = $urandom_range(1023);
         default: s = $urandom_range(4, 40);
      endcase
      case ($urandom_range(9))
         0: f = 0;
         1: f = 511;
         default: f = $urandom_range(511);
      endcase
      case ($urandom_range(9))
         0: o = -256;
         1: o = 255;
         2, 3: o = $urandom_range(511) - 256;
         default: o = $urandom_range(16) - 8;
      endcase
      write_regs(t, s, f, o);
   endtask

   // mostly filter-like coefficients, some wide and some full range
   function automatic int pick_coef();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(140) - 40;
      if (r < 85) return $urandom_range(4000) - 2000;
      return $urandom_range(65535);
   endfunction

   task automatic random_word();
      int r, x;
      pixel_result_type probe;
      r = $urandom_range(99);
      if (r < 18) begin
         load_coef($urandom_range(511), pick_coef());
      end else if (r < 36) begin
         load_pixel($urandom_range(255), $urandom_range(255));
      end else if (r < 40) begin
         send_word(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         // most computes look for an output position whose taps stay on the line
         x = $urandom_range(255);
         if ($urandom_range(99) < 80) begin
            for (int i = 0; i < 16; i++) begin
               probe = sb.filter_pixel(x);
               if (!probe.off_line) break;
               x = $urandom_range(255);
            end
         end
         compute(x);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill both stores so no compute reads an unwritten entry
      for (int i = 0; i < COEF_DEPTH; i++) load_coef(i, pick_coef());
      for (int i = 0; i < LINE_DEPTH; i++) load_pixel(i, $urandom_range(255));
      settle();

      // directed: field extremes, unused action, both line edges
      write_regs(8, 16, 0, 0);
      load_coef(0, -32768);
      load_coef(511, 32767);
      load_pixel(0, 0);
      load_pixel(255, 255);
      send_word(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      compute(0);
      compute(255);
      compute(100);
      settle();

      // single tap via zero tap count: clip low, clip high, pass through
      write_regs(0, 16, 0, 0);
      load_pixel(5, 200);
      compute(5);
      load_coef(0, 32767);
      compute(5);
      load_coef(0, 128);
      compute(5);
      settle();

      // tap count above the maximum, largest step and offsets
      write_regs(15, 1023, 511, -256);
      compute(0);
      compute(1);
      settle();
      write_regs(8, 0, 300, 255);
      compute(0);
      compute(200);
      settle();
      write_regs(2, 1, 127, 3);
      compute(50);
      compute(251);
      settle();

      // random phases, each with its own settings and idling pattern
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph == 0) write_regs(8, 16, 0, 0);
         else pick_settings();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 81; end
            default: begin send_idle_pct = 38; recv_stall_pct <= 38; end
         endcase
         // receiver backs off while the sender keeps offering
         if (ph == 0) hold_token <= hold_token + 1;
         for (int i = 0; i < PHASE_WORDS; i++) random_word();
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
